// ===== rtl/bcfg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and OCV curve for the coulomb-counting fuel gauge.
package bcfg_pkg;

    // Pack and cell geometry
    localparam int CELL_COUNT = 4;

    // Datapath widths
    localparam int ADC_W    = 12;
    localparam int RAW_W    = 16;
    localparam int TICK_W   = 32;
    localparam int MV_W     = 15;
    localparam int CUR_W    = 15;
    localparam int SOC_W    = 14;
    localparam int CAPR_W   = 16;
    localparam int CAP_W    = 38;   // capacity in mA-ms, up to 65535 * 3600000
    localparam int CHG_W    = 40;   // consumed charge in mA-ms
    localparam int MUL_W    = 47;   // current times elapsed ms
    localparam int PROD_W   = 52;   // (cap - consumed) * 10000
    localparam int SEED_W   = 30;   // (10000 - soc) * capacity_mah
    localparam int ADC_PROD_W = 27;
    localparam int ADC_SHIFT  = 12;

    // Restoring divider: the quotient always fits in DIV_BITS bits
    localparam int DIV_BITS = 14;
    localparam int CNT_W    = $clog2(DIV_BITS);

    // Microcode program counter
    localparam int UPC_W = 5;

    // Scaling constants
    localparam logic [MV_W-1:0]   ADC_SCALE      = 15'd18810;
    localparam logic [21:0]       MAMS_PER_MAH   = 22'd3600000;
    localparam logic [8:0]        MAMS_PER_CENTI = 9'd360;   // 3600000 / 10000
    localparam logic [SOC_W-1:0]  SOC_FULL       = 14'd10000;
    localparam logic [CHG_W-1:0]  CHARGE_MAX     = '1;

    // OCV curve: cell millivolts to hundredths of a percent
    localparam int OCV_PTS = 10;
    localparam int SEG_W   = $clog2(OCV_PTS);
    localparam logic [MV_W-1:0] OCV_MV [OCV_PTS] = '{
        15'd3500, 15'd3600, 15'd3680, 15'd3730, 15'd3770,
        15'd3820, 15'd3880, 15'd3950, 15'd4070, 15'd4200
    };
    localparam logic [SOC_W-1:0] OCV_SOC [OCV_PTS] = '{
        14'd0,    14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd10000
    };

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_THR = 2'd2;

    localparam logic [CAPR_W-1:0] CAP_RESET  = 16'd5000;
    localparam logic [SOC_W-1:0]  LOW_RESET  = 14'd2500;
    localparam logic [SOC_W-1:0]  CRIT_RESET = 14'd1000;

    typedef struct packed {
        logic                    op;
        logic [ADC_W-1:0]        adc_code;
        logic signed [RAW_W-1:0] current_raw_ma;
        logic [TICK_W-1:0]       now_ms;
    } t_in;

    typedef struct packed {
        logic [MV_W-1:0]  pack_mv;
        logic [CUR_W-1:0] current_ma;
        logic [SOC_W-1:0] soc_centi;
        logic             low_flag;
        logic             critical_flag;
    } t_out;

    typedef struct packed {
        logic [CAPR_W-1:0] capacity_mah;
        logic [SOC_W-1:0]  low_threshold_centi;
        logic [SOC_W-1:0]  critical_threshold_centi;
    } t_cfg;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_PACK,
        UOP_CAP,
        UOP_CHG,
        UOP_ACC,
        UOP_CMP,
        UOP_SCALE,
        UOP_DIVSET,
        UOP_DIVSTEP,
        UOP_SOCQ,
        UOP_CELL,
        UOP_SEG,
        UOP_DV,
        UOP_SOCADD,
        UOP_SEED1,
        UOP_SEED2,
        UOP_FIN
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_IDLE,
        COND_INIT,
        COND_GE,
        COND_EXT,
        COND_CNT,
        COND_OUT_BUSY
    } t_cond;

    typedef enum logic {
        DIV_CAP,
        DIV_SPAN
    } t_div_src;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_uop     op;
        t_cond    cond;
        t_upc     target;
        t_div_src div_src;
        logic     cnt_load;
        logic     cnt_dec;
    } t_ctl;

    typedef struct packed {
        logic init_op;
        logic ge;
        logic ext;
    } t_dp_stat;

    typedef struct packed {
        logic     busy;
        logic     out_block;
        t_dp_stat dp;
    } t_stat;

endpackage

// ===== rtl/battery_coulomb_fuel_gauge.sv =====
`timescale 1ns / 1ps
// Top level of the coulomb-counting battery fuel gauge with OCV initialization.
//
// One transaction in gives one transaction out. Each input transaction carries
// an op bit, a 12-bit ADC code of the divided pack voltage, a signed current in
// mA and a millisecond timestamp. The result holds pack millivolts, discharge
// current (negatives clamped to zero), state of charge in hundredths of a
// percent and the low and critical flags. A periodic update (op 0) adds current
// times elapsed ms to the consumed charge, saturating at 2^40-1, and reports
// SoC against the configured capacity. An init op (op 1) restarts the tick and
// seeds the consumed charge from a 10-point OCV curve looked up on pack_mv/4.
// Work runs on a small microcoded sequencer over a shared datapath; one item
// is in flight at a time and o_in_stall stays high while it runs.
// A periodic update and an init op each run the 14-step restoring divider (one
// quotient bit a cycle); an empty pack and a cell voltage off either end of the
// curve skip it. A new item can be taken in the cycle after the previous result
// is loaded into the output register, even while that result waits.
// Configuration writes are always ready; write them only while no item is in
// flight. Indexes: 0 capacity_mah, 1 low_threshold_centi, 2
// critical_threshold_centi; other indexes are ignored.
module battery_coulomb_fuel_gauge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bcfg_pkg::t_in                       i_in,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bcfg_pkg::t_out                      o_out,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcfg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bcfg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic               r_busy;
    logic               r_out_valid;
    bcfg_pkg::t_out     r_out;
    bcfg_pkg::t_in      r_in;
    bcfg_pkg::t_cfg     r_cfg;

    bcfg_pkg::t_ctl     ctl;
    bcfg_pkg::t_stat    stat;
    bcfg_pkg::t_dp_stat dp_stat;
    bcfg_pkg::t_out     dp_res;

    logic               in_fire;
    logic               out_block;
    logic               fin_fire;
    logic               cfg_fire;

    // Handshakes
    assign in_fire     = i_in_valid && !r_busy;
    assign out_block   = r_out_valid && i_out_stall;
    assign fin_fire    = (ctl.op == bcfg_pkg::UOP_FIN) && !out_block;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign stat.busy      = r_busy;
    assign stat.out_block = out_block;
    assign stat.dp        = dp_stat;

    bcfg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    bcfg_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cfg   (r_cfg),
        .i_in    (r_in),
        .o_res   (dp_res),
        .o_stat  (dp_stat)
    );

    // Control state: busy flag, output valid, configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy                         <= 1'b0;
            r_out_valid                    <= 1'b0;
            r_cfg.capacity_mah             <= bcfg_pkg::CAP_RESET;
            r_cfg.low_threshold_centi      <= bcfg_pkg::LOW_RESET;
            r_cfg.critical_threshold_centi <= bcfg_pkg::CRIT_RESET;
        end else begin
            // Hold busy from accept until the result moves to the output register
            if (in_fire) begin
                r_busy <= 1'b1;
            end else if (fin_fire) begin
                r_busy <= 1'b0;
            end

            // Load a finished result, drop the valid once it is taken
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_fire) begin
                unique case (i_cfg_index)
                    bcfg_pkg::CFG_CAPACITY: begin
                        r_cfg.capacity_mah <= i_cfg_data;
                    end
                    bcfg_pkg::CFG_LOW_THR: begin
                        r_cfg.low_threshold_centi <= i_cfg_data[bcfg_pkg::SOC_W-1:0];
                    end
                    bcfg_pkg::CFG_CRIT_THR: begin
                        r_cfg.critical_threshold_centi <= i_cfg_data[bcfg_pkg::SOC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
        if (fin_fire) begin
            r_out <= dp_res;
        end
    end

endmodule

// ===== rtl/bcfg_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: program counter, control store and divide loop counter.
module bcfg_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcfg_pkg::t_stat  i_stat,
    output bcfg_pkg::t_ctl   o_ctl
);

    // Step addresses
    localparam bcfg_pkg::t_upc S_WAIT   = 5'd0;
    localparam bcfg_pkg::t_upc S_PACK   = 5'd1;
    localparam bcfg_pkg::t_upc S_CAP    = 5'd2;
    localparam bcfg_pkg::t_upc S_CHG    = 5'd3;
    localparam bcfg_pkg::t_upc S_ACC    = 5'd4;
    localparam bcfg_pkg::t_upc S_CMP    = 5'd5;
    localparam bcfg_pkg::t_upc S_SCALE  = 5'd6;
    localparam bcfg_pkg::t_upc S_DIVC   = 5'd7;
    localparam bcfg_pkg::t_upc S_DSTEPC = 5'd8;
    localparam bcfg_pkg::t_upc S_SOCQ   = 5'd9;
    localparam bcfg_pkg::t_upc S_CELL   = 5'd10;
    localparam bcfg_pkg::t_upc S_SEG    = 5'd11;
    localparam bcfg_pkg::t_upc S_DV     = 5'd12;
    localparam bcfg_pkg::t_upc S_DIVS   = 5'd13;
    localparam bcfg_pkg::t_upc S_DSTEPS = 5'd14;
    localparam bcfg_pkg::t_upc S_SOCADD = 5'd15;
    localparam bcfg_pkg::t_upc S_SEED1  = 5'd16;
    localparam bcfg_pkg::t_upc S_SEED2  = 5'd17;
    localparam bcfg_pkg::t_upc S_FIN    = 5'd18;
    localparam bcfg_pkg::t_upc S_RET    = 5'd19;

    function automatic bcfg_pkg::t_ctl ucode(input bcfg_pkg::t_upc pc);
        bcfg_pkg::t_ctl w;
        w.op       = bcfg_pkg::UOP_NOP;
        w.cond     = bcfg_pkg::COND_NEXT;
        w.target   = S_WAIT;
        w.div_src  = bcfg_pkg::DIV_CAP;
        w.cnt_load = 1'b0;
        w.cnt_dec  = 1'b0;
        unique case (pc)
            S_WAIT: begin
                w.cond = bcfg_pkg::COND_IDLE;
            end
            S_PACK: begin
                w.op = bcfg_pkg::UOP_PACK;
            end
            S_CAP: begin
                w.op     = bcfg_pkg::UOP_CAP;
                w.cond   = bcfg_pkg::COND_INIT;
                w.target = S_CELL;
            end
            S_CHG: begin
                w.op = bcfg_pkg::UOP_CHG;
            end
            S_ACC: begin
                w.op = bcfg_pkg::UOP_ACC;
            end
            S_CMP: begin
                w.op = bcfg_pkg::UOP_CMP;
            end
            S_SCALE: begin
                w.op     = bcfg_pkg::UOP_SCALE;
                w.cond   = bcfg_pkg::COND_GE;
                w.target = S_FIN;
            end
            S_DIVC: begin
                w.op       = bcfg_pkg::UOP_DIVSET;
                w.div_src  = bcfg_pkg::DIV_CAP;
                w.cnt_load = 1'b1;
            end
            S_DSTEPC: begin
                w.op      = bcfg_pkg::UOP_DIVSTEP;
                w.cond    = bcfg_pkg::COND_CNT;
                w.target  = S_DSTEPC;
                w.cnt_dec = 1'b1;
            end
            S_SOCQ: begin
                w.op     = bcfg_pkg::UOP_SOCQ;
                w.cond   = bcfg_pkg::COND_ALWAYS;
                w.target = S_FIN;
            end
            S_CELL: begin
                w.op = bcfg_pkg::UOP_CELL;
            end
            S_SEG: begin
                w.op = bcfg_pkg::UOP_SEG;
            end
            S_DV: begin
                w.op     = bcfg_pkg::UOP_DV;
                w.cond   = bcfg_pkg::COND_EXT;
                w.target = S_SEED1;
            end
            S_DIVS: begin
                w.op       = bcfg_pkg::UOP_DIVSET;
                w.div_src  = bcfg_pkg::DIV_SPAN;
                w.cnt_load = 1'b1;
            end
            S_DSTEPS: begin
                w.op      = bcfg_pkg::UOP_DIVSTEP;
                w.cond    = bcfg_pkg::COND_CNT;
                w.target  = S_DSTEPS;
                w.cnt_dec = 1'b1;
            end
            S_SOCADD: begin
                w.op = bcfg_pkg::UOP_SOCADD;
            end
            S_SEED1: begin
                w.op = bcfg_pkg::UOP_SEED1;
            end
            S_SEED2: begin
                w.op     = bcfg_pkg::UOP_SEED2;
                w.cond   = bcfg_pkg::COND_ALWAYS;
                w.target = S_FIN;
            end
            S_FIN: begin
                w.op     = bcfg_pkg::UOP_FIN;
                w.cond   = bcfg_pkg::COND_OUT_BUSY;
                w.target = S_FIN;
            end
            S_RET: begin
                w.cond = bcfg_pkg::COND_ALWAYS;
            end
            default: begin
                w.cond = bcfg_pkg::COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

    bcfg_pkg::t_upc             r_pc;
    bcfg_pkg::t_upc             n_pc;
    logic [bcfg_pkg::CNT_W-1:0] r_cnt;
    logic [bcfg_pkg::CNT_W-1:0] n_cnt;
    bcfg_pkg::t_ctl             ctl;
    logic                       taken;

    assign ctl   = ucode(r_pc);
    assign o_ctl = ctl;

    always_comb begin
        case (ctl.cond)
            bcfg_pkg::COND_NEXT:     taken = 1'b0;
            bcfg_pkg::COND_ALWAYS:   taken = 1'b1;
            bcfg_pkg::COND_IDLE:     taken = !i_stat.busy;
            bcfg_pkg::COND_INIT:     taken = i_stat.dp.init_op;
            bcfg_pkg::COND_GE:       taken = i_stat.dp.ge;
            bcfg_pkg::COND_EXT:      taken = i_stat.dp.ext;
            bcfg_pkg::COND_CNT:      taken = (r_cnt != '0);
            bcfg_pkg::COND_OUT_BUSY: taken = i_stat.out_block;
            default:                 taken = 1'b0;
        endcase

        n_pc = taken ? ctl.target : r_pc + bcfg_pkg::UPC_W'(1);

        n_cnt = r_cnt;
        if (ctl.cnt_load) begin
            n_cnt = bcfg_pkg::CNT_W'(bcfg_pkg::DIV_BITS - 1);
        end else if (ctl.cnt_dec && (r_cnt != '0)) begin
            n_cnt = r_cnt - bcfg_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= S_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/bcfg_dpath.sv =====
`timescale 1ns / 1ps
// Fuel gauge datapath: scaling, charge accumulator, OCV lookup and shared divider.
module bcfg_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcfg_pkg::t_ctl      i_ctl,
    input  bcfg_pkg::t_cfg      i_cfg,
    input  bcfg_pkg::t_in       i_in,
    output bcfg_pkg::t_out      o_res,
    output bcfg_pkg::t_dp_stat  o_stat
);

    // Architectural state
    logic [bcfg_pkg::TICK_W-1:0]   r_tick, n_tick;
    logic [bcfg_pkg::CHG_W-1:0]    r_chg,  n_chg;

    // Working registers
    logic [bcfg_pkg::MV_W-1:0]     r_pack_mv, n_pack_mv;
    logic [bcfg_pkg::CUR_W-1:0]    r_cur,     n_cur;
    logic [bcfg_pkg::CAP_W-1:0]    r_cap,     n_cap;
    logic [bcfg_pkg::PROD_W-1:0]   r_prod,    n_prod;
    logic [bcfg_pkg::CAP_W-1:0]    r_rem,     n_rem;
    logic [bcfg_pkg::CAP_W-1:0]    r_div,     n_div;
    logic [bcfg_pkg::DIV_BITS-1:0] r_quo,     n_quo;
    logic [bcfg_pkg::SOC_W-1:0]    r_soc,     n_soc;
    logic [bcfg_pkg::MV_W-1:0]     r_cell,    n_cell;
    logic [bcfg_pkg::SEG_W-1:0]    r_seg,     n_seg;
    logic                          r_ge,      n_ge;
    logic                          r_ext,     n_ext;

    // Combinational helpers
    logic [bcfg_pkg::CAPR_W-1:0]     cap_eff;
    logic [bcfg_pkg::ADC_PROD_W-1:0] pack_prod;
    logic [bcfg_pkg::TICK_W-1:0]     dt;
    logic [bcfg_pkg::MUL_W-1:0]      chg_mul;
    logic [bcfg_pkg::MUL_W:0]        acc_sum;
    logic [bcfg_pkg::CAP_W:0]        div_sh;
    logic                            div_ge;
    logic [bcfg_pkg::CAP_W:0]        div_diff;
    logic [bcfg_pkg::SEG_W-1:0]      seg_find;
    logic [bcfg_pkg::SEG_W-1:0]      seg_nxt;
    logic [bcfg_pkg::MV_W-1:0]       dv;
    logic [bcfg_pkg::MV_W-1:0]       span;
    logic [bcfg_pkg::SOC_W-1:0]      ds;

    always_comb begin
        cap_eff   = (i_cfg.capacity_mah == '0) ? bcfg_pkg::CAPR_W'(1) : i_cfg.capacity_mah;
        pack_prod = bcfg_pkg::ADC_PROD_W'(i_in.adc_code)
                  * bcfg_pkg::ADC_PROD_W'(bcfg_pkg::ADC_SCALE);
        dt        = i_in.now_ms - r_tick;
        chg_mul   = bcfg_pkg::MUL_W'(r_cur) * bcfg_pkg::MUL_W'(dt);
        acc_sum   = (bcfg_pkg::MUL_W + 1)'(r_chg)
                  + (bcfg_pkg::MUL_W + 1)'(r_prod[bcfg_pkg::MUL_W-1:0]);

        // One restoring divide step: bring down the next dividend bit
        div_sh   = {r_rem, r_quo[bcfg_pkg::DIV_BITS-1]};
        div_ge   = (div_sh >= {1'b0, r_div});
        div_diff = div_sh - {1'b0, r_div};

        // Segment whose lower breakpoint is the last one at or below the cell voltage
        seg_find = '0;
        for (int i = 1; i < bcfg_pkg::OCV_PTS - 1; i++) begin
            if (r_cell >= bcfg_pkg::OCV_MV[i]) begin
                seg_find = bcfg_pkg::SEG_W'(i);
            end
        end

        seg_nxt = r_seg + bcfg_pkg::SEG_W'(1);
        dv      = r_cell - bcfg_pkg::OCV_MV[r_seg];
        span    = bcfg_pkg::OCV_MV[seg_nxt] - bcfg_pkg::OCV_MV[r_seg];
        ds      = bcfg_pkg::OCV_SOC[seg_nxt] - bcfg_pkg::OCV_SOC[r_seg];

        // Hold by default
        n_tick    = r_tick;
        n_chg     = r_chg;
        n_pack_mv = r_pack_mv;
        n_cur     = r_cur;
        n_cap     = r_cap;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_div     = r_div;
        n_quo     = r_quo;
        n_soc     = r_soc;
        n_cell    = r_cell;
        n_seg     = r_seg;
        n_ge      = r_ge;
        n_ext     = r_ext;

        unique case (i_ctl.op)
            bcfg_pkg::UOP_NOP, bcfg_pkg::UOP_FIN: begin
            end
            bcfg_pkg::UOP_PACK: begin
                n_pack_mv = pack_prod[bcfg_pkg::ADC_SHIFT +: bcfg_pkg::MV_W];
                n_cur     = i_in.current_raw_ma[bcfg_pkg::RAW_W-1]
                          ? '0 : i_in.current_raw_ma[bcfg_pkg::CUR_W-1:0];
            end
            bcfg_pkg::UOP_CAP: begin
                n_cap = bcfg_pkg::CAP_W'(cap_eff) * bcfg_pkg::CAP_W'(bcfg_pkg::MAMS_PER_MAH);
            end
            bcfg_pkg::UOP_CHG: begin
                n_prod = bcfg_pkg::PROD_W'(chg_mul);
                n_tick = i_in.now_ms;
            end
            bcfg_pkg::UOP_ACC: begin
                // Saturate at full scale
                if (acc_sum >= (bcfg_pkg::MUL_W + 1)'(bcfg_pkg::CHARGE_MAX)) begin
                    n_chg = bcfg_pkg::CHARGE_MAX;
                end else begin
                    n_chg = acc_sum[bcfg_pkg::CHG_W-1:0];
                end
            end
            bcfg_pkg::UOP_CMP: begin
                n_ge   = (r_chg >= bcfg_pkg::CHG_W'(r_cap));
                n_prod = bcfg_pkg::PROD_W'(r_cap - r_chg[bcfg_pkg::CAP_W-1:0]);
                n_soc  = '0;
            end
            bcfg_pkg::UOP_SCALE: begin
                n_prod = bcfg_pkg::PROD_W'(r_prod[bcfg_pkg::CAP_W-1:0])
                       * bcfg_pkg::PROD_W'(bcfg_pkg::SOC_FULL);
            end
            bcfg_pkg::UOP_DIVSET: begin
                n_rem = r_prod[bcfg_pkg::PROD_W-1:bcfg_pkg::DIV_BITS];
                n_quo = r_prod[bcfg_pkg::DIV_BITS-1:0];
                n_div = (i_ctl.div_src == bcfg_pkg::DIV_SPAN)
                      ? bcfg_pkg::CAP_W'(span) : r_cap;
            end
            bcfg_pkg::UOP_DIVSTEP: begin
                n_rem = div_ge ? div_diff[bcfg_pkg::CAP_W-1:0] : div_sh[bcfg_pkg::CAP_W-1:0];
                n_quo = {r_quo[bcfg_pkg::DIV_BITS-2:0], div_ge};
            end
            bcfg_pkg::UOP_SOCQ: begin
                n_soc = r_quo;
            end
            bcfg_pkg::UOP_CELL: begin
                n_cell = bcfg_pkg::MV_W'(r_pack_mv / bcfg_pkg::CELL_COUNT);
                n_tick = i_in.now_ms;
            end
            bcfg_pkg::UOP_SEG: begin
                n_seg = seg_find;
                if (r_cell <= bcfg_pkg::OCV_MV[0]) begin
                    n_ext = 1'b1;
                    n_soc = bcfg_pkg::OCV_SOC[0];
                end else if (r_cell >= bcfg_pkg::OCV_MV[bcfg_pkg::OCV_PTS-1]) begin
                    n_ext = 1'b1;
                    n_soc = bcfg_pkg::OCV_SOC[bcfg_pkg::OCV_PTS-1];
                end else begin
                    n_ext = 1'b0;
                end
            end
            bcfg_pkg::UOP_DV: begin
                n_prod = bcfg_pkg::PROD_W'(dv) * bcfg_pkg::PROD_W'(ds);
            end
            bcfg_pkg::UOP_SOCADD: begin
                n_soc = bcfg_pkg::OCV_SOC[r_seg] + r_quo;
            end
            bcfg_pkg::UOP_SEED1: begin
                n_prod = bcfg_pkg::PROD_W'(bcfg_pkg::SOC_FULL - r_soc)
                       * bcfg_pkg::PROD_W'(cap_eff);
            end
            bcfg_pkg::UOP_SEED2: begin
                // cap / 10000 is exactly cap_eff * 360
                n_chg = bcfg_pkg::CHG_W'(r_prod[bcfg_pkg::SEED_W-1:0])
                      * bcfg_pkg::CHG_W'(bcfg_pkg::MAMS_PER_CENTI);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_chg  <= '0;
        end else begin
            r_tick <= n_tick;
            r_chg  <= n_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pack_mv <= n_pack_mv;
        r_cur     <= n_cur;
        r_cap     <= n_cap;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_quo     <= n_quo;
        r_soc     <= n_soc;
        r_cell    <= n_cell;
        r_seg     <= n_seg;
        r_ge      <= n_ge;
        r_ext     <= n_ext;
    end

    assign o_res.pack_mv       = r_pack_mv;
    assign o_res.current_ma    = r_cur;
    assign o_res.soc_centi     = r_soc;
    assign o_res.low_flag      = (r_soc < i_cfg.low_threshold_centi);
    assign o_res.critical_flag = (r_soc < i_cfg.critical_threshold_centi);

    assign o_stat.init_op = i_in.op;
    assign o_stat.ge      = r_ge;
    assign o_stat.ext     = r_ext;

endmodule
